>>> rtl/stem_darkening_amount_top_assert.svh
// Assertion macros for the stem darkening amount block.
// Needs clk and rst_n in the scope of each use.
`ifndef STEM_DARKENING_AMOUNT_TOP_ASSERT_SVH
`define STEM_DARKENING_AMOUNT_TOP_ASSERT_SVH

// Check a property on every clock edge out of reset.
`define SDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define SDA_CHECK_STABLE(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) else $error(msg);

`endif

>>> rtl/sda_pkg.sv
// Shared constants, sideband types and fixed-point helpers for stem darkening.
// No dependencies.
package sda_pkg;

  localparam int KNEE_CNT  = 8;
  localparam int KNEE_PTS  = 4;
  localparam int KNEE_W    = 15;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the knee file
  localparam logic [CFG_IDX_W-1:0] KNEE1_STEM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] KNEE1_AMOUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] KNEE2_STEM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] KNEE2_AMOUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] KNEE3_STEM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] KNEE3_AMOUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] KNEE4_STEM   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] KNEE4_AMOUNT = 3'd7;

  localparam logic [KNEE_W-1:0] KNEE_RESET [KNEE_CNT] = '{
    15'd500, 15'd400, 15'd1000, 15'd275, 15'd1667, 15'd275, 15'd2333, 15'd0
  };

  // Em ratio below 0.01 in 16.16 gives a zero result
  localparam logic [30:0] EM_MIN     = 31'd655;
  // Top-bit sum at which the scaled stem is clamped to the last knee
  localparam logic [5:0]  GUARD_BITS = 6'd46;
  localparam logic [31:0] SAT_Q      = 32'h7FFF_FFFF;

  // Divider geometry: one quotient bit per stage
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 32;

  localparam logic [1:0] SKID_DEPTH = 2'd2;

  // Sideband through the knee amount divider
  typedef struct packed {
    logic [31:0]        per1000;
    logic signed [15:0] yd;
    logic signed [15:0] xd;
    logic               sloped;
    logic               ppem_zero;
    logic [30:0]        em;
    logic signed [31:0] bold;
    logic               en;
    logic               zero;
  } side_a_t;

  // Sideband through the slope divider
  typedef struct packed {
    logic signed [31:0] ybase;
    logic               neg;
    logic               sloped;
    logic [30:0]        em;
    logic signed [31:0] bold;
    logic               en;
    logic               zero;
  } side_b_t;

  // Sideband through the final em divider
  typedef struct packed {
    logic               neg;
    logic               dzero;
    logic signed [31:0] bold;
    logic               en;
    logic               zero;
  } side_c_t;

  localparam int SIDE_W   = $bits(side_a_t);
  localparam int SIDE_B_W = $bits(side_b_t);
  localparam int SIDE_C_W = $bits(side_c_t);

  typedef logic [SIDE_W-1:0] side_t;

  // Magnitude of a 32-bit two's complement word
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  // Round a 16.16 product magnitude and apply its sign, wrapping to 32 bits
  function automatic logic [31:0] fix_round(input logic [62:0] p, input logic neg);
    logic [62:0] r;
    logic [31:0] m;
    r = p + 63'h8000;
    m = r[47:16];
    return neg ? 32'(-m) : m;
  endfunction

  // Index of the highest set bit, zero for zero
  function automatic logic [4:0] top_bit(input logic [31:0] z);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (z[i]) n = 5'(i);
    end
    return n;
  endfunction

endpackage

>>> rtl/sda_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on sda_pkg.
module sda_div_pipe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [sda_pkg::DIV_NUM_W-1:0]   in_num,
  input  logic [sda_pkg::DIV_DEN_W-1:0]   in_den,
  input  sda_pkg::side_t                  in_side,
  output logic                            out_valid,
  output logic [sda_pkg::DIV_NUM_W-1:0]   out_quo,
  output sda_pkg::side_t                  out_side
);

  localparam int NW = sda_pkg::DIV_NUM_W;
  localparam int DW = sda_pkg::DIV_DEN_W;

  logic          valid_r [NW];
  logic [DW-1:0] rem_r   [NW];
  logic [NW-1:0] num_r   [NW];
  logic [DW-1:0] den_r   [NW];
  sda_pkg::side_t side_r [NW];

  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] num_nxt [NW];

  // One shift-compare-subtract step per stage
  always_comb begin
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   sh;
    logic [DW+1:0] trial;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        rem_in = '0;
        num_in = in_num;
        den_in = in_den;
      end else begin
        rem_in = rem_r[k-1];
        num_in = num_r[k-1];
        den_in = den_r[k-1];
      end
      sh    = {rem_in, num_in[NW-1]};
      trial = {1'b0, sh} - {2'b00, den_in};
      if (!trial[DW+1]) begin
        rem_nxt[k] = trial[DW-1:0];
        num_nxt[k] = {num_in[NW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[DW-1:0];
        num_nxt[k] = {num_in[NW-2:0], 1'b0};
      end
    end
  end

  // Advance valid bits with the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) valid_r[k] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int k = 1; k < NW; k++) valid_r[k] <= valid_r[k-1];
    end
  end

  // Advance payload; hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
      end
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int k = 1; k < NW; k++) begin
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = valid_r[NW-1];
  assign out_quo   = num_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

>>> rtl/sda_out_skid.sv
// Two-word output buffer that parts the pipeline from the result channel.
// Depends on sda_pkg and the assertion macro header.
`include "stem_darkening_amount_top_assert.svh"

module sda_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [31:0] in_data,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_data
);

  logic [1:0]         cnt_r, cnt_nxt;
  logic signed [31:0] data0_r, data0_nxt;
  logic signed [31:0] data1_r, data1_nxt;
  logic               push, pop;

  assign room      = (cnt_r != sda_pkg::SKID_DEPTH);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = data0_r;
  assign push      = in_valid && room;
  assign pop       = out_valid && out_ready;

  // Update fill count and the two words
  always_comb begin
    cnt_nxt   = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    data0_nxt = data0_r;
    data1_nxt = data1_r;
    if (cnt_r == 2'd0) begin
      if (push) data0_nxt = in_data;
    end else if (cnt_r == 2'd1) begin
      if (push && pop) data0_nxt = in_data;
      else if (push) data1_nxt = in_data;
    end else if (pop) begin
      data0_nxt = data1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data0_r <= data0_nxt;
    data1_r <= data1_nxt;
  end

  `SDA_ASSERT(a_skid_bound, cnt_r <= sda_pkg::SKID_DEPTH, "skid count above depth")
  `SDA_ASSERT(a_skid_drain, pop && !push |=> cnt_r == $past(cnt_r) - 2'd1, "drain lost count")
  `SDA_CHECK_STABLE(a_skid_hold, out_valid && !pop && !push, data0_r, "head word changed while idle")

endmodule

>>> rtl/stem_darkening_amount_top.sv
// Stem darkening amount: pipelined from input accept to out_valid.
// Throughput one word per cycle while the output buffer has room; uses four 48-stage dividers.
// Up to two results wait in the output buffer; when it is full, the pipeline and input stall.
// Synchronous active-low reset restores the knee registers and empties the pipeline.
// Depends on sda_pkg, sda_div_pipe and sda_out_skid.
module stem_darkening_amount_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [30:0]        in_em_ratio,
  input  logic [30:0]        in_pixels_per_em,
  input  logic signed [31:0] in_stem_width,
  input  logic signed [31:0] in_embolden_amount,
  input  logic               in_darken_enable,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_darken_amount,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_wdata
);

  logic adv;

  // Knee register file
  logic [14:0] knee_r [sda_pkg::KNEE_CNT];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sda_pkg::KNEE_CNT; i++) knee_r[i] <= sda_pkg::KNEE_RESET[i];
    end else if (cfg_valid && cfg_ready) begin
      knee_r[cfg_index] <= cfg_wdata;
    end
  end

  logic [14:0] xs [sda_pkg::KNEE_PTS];
  logic [14:0] ys [sda_pkg::KNEE_PTS];
  assign xs[0] = knee_r[sda_pkg::KNEE1_STEM];
  assign ys[0] = knee_r[sda_pkg::KNEE1_AMOUNT];
  assign xs[1] = knee_r[sda_pkg::KNEE2_STEM];
  assign ys[1] = knee_r[sda_pkg::KNEE2_AMOUNT];
  assign xs[2] = knee_r[sda_pkg::KNEE3_STEM];
  assign ys[2] = knee_r[sda_pkg::KNEE3_AMOUNT];
  assign xs[3] = knee_r[sda_pkg::KNEE4_STEM];
  assign ys[3] = knee_r[sda_pkg::KNEE4_AMOUNT];

  assign in_ready = adv;

  // Stage 1: stem plus emboldening times em ratio
  logic               s1_v_r;
  logic [62:0]        s1_prod_r;
  logic               s1_neg_r;
  logic [30:0]        s1_em_r, s1_ppem_r;
  logic signed [31:0] s1_bold_r;
  logic               s1_en_r, s1_zero_r;
  logic [31:0]        in_sum;

  assign in_sum = in_stem_width + in_embolden_amount;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r <= 63'(sda_pkg::mag32(in_sum)) * 63'(in_em_ratio);
      s1_neg_r  <= in_sum[31];
      s1_em_r   <= in_em_ratio;
      s1_ppem_r <= in_pixels_per_em;
      s1_bold_r <= in_embolden_amount;
      s1_en_r   <= in_darken_enable;
      s1_zero_r <= ((in_embolden_amount == 32'sd0) && !in_darken_enable) ||
                   (in_em_ratio < sda_pkg::EM_MIN);
    end
  end

  // Stage 2: round to the per-thousand stem
  logic               s2_v_r;
  logic [31:0]        s2_per_r;
  logic [30:0]        s2_em_r, s2_ppem_r;
  logic signed [31:0] s2_bold_r;
  logic               s2_en_r, s2_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_per_r  <= sda_pkg::fix_round(s1_prod_r, s1_neg_r);
      s2_em_r   <= s1_em_r;
      s2_ppem_r <= s1_ppem_r;
      s2_bold_r <= s1_bold_r;
      s2_en_r   <= s1_en_r;
      s2_zero_r <= s1_zero_r;
    end
  end

  // Stage 3: scale by pixels per em, flag overflow
  logic               s3_v_r;
  logic [62:0]        s3_prod_r;
  logic               s3_neg_r, s3_guard_r;
  logic [31:0]        s3_per_r;
  logic [30:0]        s3_em_r, s3_ppem_r;
  logic signed [31:0] s3_bold_r;
  logic               s3_en_r, s3_zero_r;
  logic [5:0]         bit_sum;

  assign bit_sum = {1'b0, sda_pkg::top_bit(s2_per_r)} +
                   {1'b0, sda_pkg::top_bit({1'b0, s2_ppem_r})};

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_prod_r  <= 63'(sda_pkg::mag32(s2_per_r)) * 63'(s2_ppem_r);
      s3_neg_r   <= s2_per_r[31];
      s3_guard_r <= (bit_sum >= sda_pkg::GUARD_BITS);
      s3_per_r   <= s2_per_r;
      s3_em_r    <= s2_em_r;
      s3_ppem_r  <= s2_ppem_r;
      s3_bold_r  <= s2_bold_r;
      s3_en_r    <= s2_en_r;
      s3_zero_r  <= s2_zero_r;
    end
  end

  // Stage 4: pick the segment, skipping zero-width ones, and set up the knee divides
  logic [31:0]        scaled;
  logic [3:0]         lt;
  logic [2:0]         seg;
  logic [1:0]         e_idx, eb_idx;
  logic               found;
  logic [14:0]        xbase, ybase;
  logic signed [15:0] yd, xd;

  assign scaled = s3_guard_r ? {1'b0, xs[sda_pkg::KNEE_PTS-1], 16'b0}
                             : sda_pkg::fix_round(s3_prod_r, s3_neg_r);

  always_comb begin
    for (int k = 0; k < sda_pkg::KNEE_PTS; k++) begin
      lt[k] = ($signed(scaled) < $signed({1'b0, xs[k], 16'b0}));
    end
    seg = 3'(sda_pkg::KNEE_PTS);
    for (int k = sda_pkg::KNEE_PTS - 1; k >= 0; k--) begin
      if (lt[k]) seg = 3'(k);
    end
    found = 1'b0;
    e_idx = 2'd1;
    for (int k = 1; k < sda_pkg::KNEE_PTS; k++) begin
      if (!found && seg != 3'd0 && 3'(k) >= seg && xs[k] != xs[k-1]) begin
        found = 1'b1;
        e_idx = 2'(k);
      end
    end
    eb_idx = e_idx - 2'd1;
    xbase  = xs[eb_idx];
    if (found) ybase = ys[eb_idx];
    else if (seg == 3'd0) ybase = ys[0];
    else ybase = ys[sda_pkg::KNEE_PTS-1];
    yd = $signed({1'b0, ys[e_idx]}) - $signed({1'b0, ys[eb_idx]});
    xd = $signed({1'b0, xs[e_idx]}) - $signed({1'b0, xs[eb_idx]});
  end

  logic                              s4_v_r;
  logic [sda_pkg::DIV_NUM_W-1:0]     s4_numx_r, s4_numy_r;
  logic [sda_pkg::DIV_DEN_W-1:0]     s4_den_r;
  sda_pkg::side_a_t                  s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_numx_r <= 48'({xbase, 32'b0}) + 48'(s3_ppem_r[30:1]);
      s4_numy_r <= 48'({ybase, 32'b0}) + 48'(s3_ppem_r[30:1]);
      s4_den_r  <= {1'b0, s3_ppem_r};
      s4_side_r.per1000   <= s3_per_r;
      s4_side_r.yd        <= yd;
      s4_side_r.xd        <= xd;
      s4_side_r.sloped    <= found;
      s4_side_r.ppem_zero <= (s3_ppem_r == 31'd0);
      s4_side_r.em        <= s3_em_r;
      s4_side_r.bold      <= s3_bold_r;
      s4_side_r.en        <= s3_en_r;
      s4_side_r.zero      <= s3_zero_r;
    end
  end

  // Knee stems and amounts divided by pixels per em
  logic                          va;
  logic [sda_pkg::DIV_NUM_W-1:0] qx, qy;
  sda_pkg::side_t                side_a_raw;
  sda_pkg::side_a_t              sa;

  sda_div_pipe u_div_x (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(s4_v_r), .in_num(s4_numx_r), .in_den(s4_den_r), .in_side('0),
    .out_valid(), .out_quo(qx), .out_side()
  );

  sda_div_pipe u_div_y (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(s4_v_r), .in_num(s4_numy_r), .in_den(s4_den_r), .in_side(s4_side_r),
    .out_valid(va), .out_quo(qy), .out_side(side_a_raw)
  );

  assign sa = side_a_raw;

  // Stage 5: offset into the segment
  logic [31:0]      bx, by;
  logic             s5_v_r;
  logic [31:0]      s5_x_r, s5_by_r;
  sda_pkg::side_a_t s5_side_r;

  assign bx = sa.ppem_zero ? sda_pkg::SAT_Q : qx[31:0];
  assign by = sa.ppem_zero ? sda_pkg::SAT_Q : qy[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= va;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_x_r    <= sa.per1000 - bx;
      s5_by_r   <= by;
      s5_side_r <= sa;
    end
  end

  // Stage 6: offset times amount rise
  logic [15:0]      yd_mag, xd_mag;
  logic             s6_v_r;
  logic [47:0]      s6_prod_r;
  logic [15:0]      s6_xdmag_r;
  logic             s6_neg_r;
  logic [31:0]      s6_by_r;
  sda_pkg::side_a_t s6_side_r;

  assign yd_mag = s5_side_r.yd[15] ? 16'(-s5_side_r.yd) : s5_side_r.yd;
  assign xd_mag = s5_side_r.xd[15] ? 16'(-s5_side_r.xd) : s5_side_r.xd;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (adv) s6_v_r <= s5_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_prod_r  <= 48'(sda_pkg::mag32(s5_x_r)) * 48'(yd_mag);
      s6_xdmag_r <= xd_mag;
      s6_neg_r   <= s5_x_r[31] ^ s5_side_r.yd[15] ^ s5_side_r.xd[15];
      s6_by_r    <= s5_by_r;
      s6_side_r  <= s5_side_r;
    end
  end

  // Stage 7: set up the slope divide by stem run
  logic                          s7_v_r;
  logic [sda_pkg::DIV_NUM_W-1:0] s7_num_r;
  logic [sda_pkg::DIV_DEN_W-1:0] s7_den_r;
  sda_pkg::side_b_t              s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= s6_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_num_r         <= s6_prod_r + 48'(s6_xdmag_r[15:1]);
      s7_den_r         <= 32'(s6_xdmag_r);
      s7_side_r.ybase  <= s6_by_r;
      s7_side_r.neg    <= s6_neg_r;
      s7_side_r.sloped <= s6_side_r.sloped;
      s7_side_r.em     <= s6_side_r.em;
      s7_side_r.bold   <= s6_side_r.bold;
      s7_side_r.en     <= s6_side_r.en;
      s7_side_r.zero   <= s6_side_r.zero;
    end
  end

  logic                          vb;
  logic [sda_pkg::DIV_NUM_W-1:0] qb;
  sda_pkg::side_t                side_b_raw;
  sda_pkg::side_b_t              sb;

  sda_div_pipe u_div_slope (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(s7_v_r), .in_num(s7_num_r), .in_den(s7_den_r),
    .in_side({{(sda_pkg::SIDE_W - sda_pkg::SIDE_B_W){1'b0}}, s7_side_r}),
    .out_valid(vb), .out_quo(qb), .out_side(side_b_raw)
  );

  assign sb = side_b_raw[sda_pkg::SIDE_B_W-1:0];

  // Stage 8: curve value in font units
  logic [31:0]        slope_q;
  logic               s8_v_r;
  logic [31:0]        s8_amt_r;
  logic [30:0]        s8_em_r;
  logic signed [31:0] s8_bold_r;
  logic               s8_en_r, s8_zero_r;

  assign slope_q = sb.neg ? 32'(-qb[31:0]) : qb[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (adv) s8_v_r <= vb;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_amt_r  <= sb.sloped ? slope_q + sb.ybase : sb.ybase;
      s8_em_r   <= sb.em;
      s8_bold_r <= sb.bold;
      s8_en_r   <= sb.en;
      s8_zero_r <= sb.zero;
    end
  end

  // Stage 9: set up the divide by twice the em ratio
  logic [31:0]                   em2, em2_mag;
  logic                          s9_v_r;
  logic [sda_pkg::DIV_NUM_W-1:0] s9_num_r;
  logic [sda_pkg::DIV_DEN_W-1:0] s9_den_r;
  sda_pkg::side_c_t              s9_side_r;

  assign em2     = {s8_em_r, 1'b0};
  assign em2_mag = sda_pkg::mag32(em2);

  always_ff @(posedge clk) begin
    if (!rst_n) s9_v_r <= 1'b0;
    else if (adv) s9_v_r <= s8_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_num_r        <= 48'({sda_pkg::mag32(s8_amt_r), 16'b0}) + 48'(em2_mag[31:1]);
      s9_den_r        <= em2_mag;
      s9_side_r.neg   <= s8_amt_r[31] ^ em2[31];
      s9_side_r.dzero <= (em2_mag == 32'd0);
      s9_side_r.bold  <= s8_bold_r;
      s9_side_r.en    <= s8_en_r;
      s9_side_r.zero  <= s8_zero_r;
    end
  end

  logic                          vc;
  logic [sda_pkg::DIV_NUM_W-1:0] qc;
  sda_pkg::side_t                side_c_raw;
  sda_pkg::side_c_t              sc;

  sda_div_pipe u_div_em (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(s9_v_r), .in_num(s9_num_r), .in_den(s9_den_r),
    .in_side({{(sda_pkg::SIDE_W - sda_pkg::SIDE_C_W){1'b0}}, s9_side_r}),
    .out_valid(vc), .out_quo(qc), .out_side(side_c_raw)
  );

  assign sc = side_c_raw[sda_pkg::SIDE_C_W-1:0];

  // Per-side amount plus half the emboldening, toward zero
  logic [31:0]        em_q, em_res;
  logic signed [31:0] bold_adj, half_bold, result;

  assign em_q      = sc.dzero ? sda_pkg::SAT_Q : qc[31:0];
  assign em_res    = sc.neg ? 32'(-em_q) : em_q;
  assign bold_adj  = sc.bold + $signed({31'b0, sc.bold[31]});
  assign half_bold = bold_adj >>> 1;
  assign result    = sc.zero ? 32'sd0
                   : (sc.en ? $signed(em_res) : 32'sd0) + half_bold;

  sda_out_skid u_out (
    .clk(clk), .rst_n(rst_n),
    .in_valid(vc), .in_data(result), .room(adv),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_darken_amount)
  );

endmodule
